[sv/ple_pkg.sv]
package ple_pkg;

	// Command codes carried on the command port. Code 7 has no meaning and is
	// answered with a single done response.
	typedef enum logic [2:0] {
		CMD_INS_HEAD = 3'd0,
		CMD_INS_TAIL = 3'd1,
		CMD_INS_AT   = 3'd2,
		CMD_DEL_HEAD = 3'd3,
		CMD_DEL_TAIL = 3'd4,
		CMD_DEL_AT   = 3'd5,
		CMD_DUMP     = 3'd6
	} cmd_t;

	// Response status codes.
	typedef logic [1:0] status_t;
	localparam status_t ST_DONE = 2'd0;
	localparam status_t ST_FULL = 2'd1;
	localparam status_t ST_NONE = 2'd2;

	// Sequencer states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_INS_CHECK,
		S_INS_WR,
		S_DEL_CHECK,
		S_DEL_WR,
		S_DUMP_RD,
		S_DUMP_OUT,
		S_RESP
	} state_t;

	localparam int POS_W = 8;
	localparam int VAL_W = 32;
	localparam int CNT_W = 5;

endpackage

[sv/positional_list_engine.sv]
// Ordered list of signed 32-bit values in a store of CAPACITY entries with
// one write and one registered read port, driven by a sequencer that moves
// one element at a time, reading the neighbour and then writing it back.
// The block takes a request only while the sequencer is idle; a finished
// response may still sit in the output register while the next request is
// taken. An insert at index i shifts the elements from the tail down to i,
// a delete at i shifts those above i down, and a dump reads each element
// only once the previous one is in the output register. An insert into a
// full list is dropped with status 1; a delete that finds nothing removes
// nothing and gives status 2. Every request yields one response, except a
// non-empty dump: one response per element, with last set on the final one.
module positional_list_engine #(
	parameter int CAPACITY = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [2:0]              command,
	input  logic signed [31:0]      item_value,
	input  logic signed [7:0]       position,
	output logic                    out_valid,
	input  logic                    out_ready,
	output ple_pkg::status_t        status,
	output logic [4:0]              element_count,
	output logic                    has_element,
	output logic signed [31:0]      element_value,
	output logic                    last
);
	import ple_pkg::*;

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int LW = $clog2(CAPACITY + 1);
	localparam int CW = (LW > POS_W - 1) ? LW : POS_W - 1;

	// Element store: one write and one registered read per cycle.
	logic [VAL_W-1:0] mem [CAPACITY];
	logic [VAL_W-1:0] rdata_q;
	logic             we_c;
	logic [IW-1:0]    waddr_c;
	logic [VAL_W-1:0] wdata_c;
	logic             re_c;
	logic [IW-1:0]    raddr_c;

	// Sequencer registers.
	state_t           state_q, state_d;
	logic [LW-1:0]    length_q, length_d;
	logic [IW-1:0]    cursor_q, cursor_d;
	logic [IW-1:0]    target_q, target_d;
	logic [VAL_W-1:0] value_q, value_d;
	status_t          status_q, status_d;

	// Output register.
	logic             out_valid_q;
	status_t          out_status_q;
	logic [LW-1:0]    out_len_q;
	logic             out_has_q;
	logic [VAL_W-1:0] out_value_q;
	logic             out_last_q;
	logic             out_load_c;
	logic             out_has_c;
	logic [VAL_W-1:0] out_value_c;
	logic             out_last_c;
	status_t          out_status_c;
	logic             out_free;

	// Request decode: positions widened to a common compare width.
	logic             pos_neg;
	logic [CW-1:0]    pos_mag;
	logic [CW-1:0]    len_cw;
	logic [CW-1:0]    ins_idx;
	logic [LW-1:0]    cursor_nx;
	logic [31:0]      len_ext;

	assign pos_neg = position[POS_W-1];
	assign pos_mag = CW'(position[POS_W-2:0]);
	assign len_cw  = CW'(length_q);
	assign ins_idx = (pos_mag >= len_cw) ? len_cw : pos_mag;
	assign cursor_nx = LW'(cursor_q) + LW'(1);

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE);

	// Next state, store control and response loading.
	always_comb begin
		state_d      = state_q;
		length_d     = length_q;
		cursor_d     = cursor_q;
		target_d     = target_q;
		value_d      = value_q;
		status_d     = status_q;
		we_c         = 1'b0;
		waddr_c      = cursor_q;
		wdata_c      = rdata_q;
		re_c         = 1'b0;
		raddr_c      = cursor_q;
		out_load_c   = 1'b0;
		out_has_c    = 1'b0;
		out_value_c  = '0;
		out_last_c   = 1'b1;
		out_status_c = status_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					value_d  = item_value;
					status_d = ST_DONE;
					cursor_d = length_q[IW-1:0];
					case (command)
						CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_AT: begin
							if (length_q == LW'(CAPACITY)) begin
								status_d = ST_FULL;
								state_d  = S_RESP;
							end else begin
								state_d = S_INS_CHECK;
								if (command == CMD_INS_HEAD) begin
									target_d = '0;
								end else if (command == CMD_INS_TAIL) begin
									target_d = length_q[IW-1:0];
								end else if (pos_neg) begin
									target_d = '0;
								end else begin
									target_d = ins_idx[IW-1:0];
								end
							end
						end
						CMD_DEL_HEAD, CMD_DEL_TAIL: begin
							if (length_q == '0) begin
								status_d = ST_NONE;
								state_d  = S_RESP;
							end else begin
								state_d = S_DEL_CHECK;
								if (command == CMD_DEL_HEAD) begin
									cursor_d = '0;
								end else begin
									cursor_d = IW'(length_q - LW'(1));
								end
							end
						end
						CMD_DEL_AT: begin
							if (pos_neg || pos_mag >= len_cw) begin
								status_d = ST_NONE;
								state_d  = S_RESP;
							end else begin
								cursor_d = pos_mag[IW-1:0];
								state_d  = S_DEL_CHECK;
							end
						end
						CMD_DUMP: begin
							cursor_d = '0;
							if (length_q == '0) begin
								state_d = S_RESP;
							end else begin
								state_d = S_DUMP_RD;
							end
						end
						default: begin
							state_d = S_RESP;
						end
					endcase
				end
			end
			// Insert: move elements up one place from the tail down to the target.
			S_INS_CHECK: begin
				if (cursor_q == target_q) begin
					we_c     = 1'b1;
					wdata_c  = value_q;
					length_d = length_q + LW'(1);
					state_d  = S_RESP;
				end else begin
					re_c    = 1'b1;
					raddr_c = cursor_q - IW'(1);
					state_d = S_INS_WR;
				end
			end
			S_INS_WR: begin
				we_c     = 1'b1;
				cursor_d = cursor_q - IW'(1);
				state_d  = S_INS_CHECK;
			end
			// Delete: move elements down one place from the target to the tail.
			S_DEL_CHECK: begin
				if (cursor_nx >= length_q) begin
					length_d = length_q - LW'(1);
					state_d  = S_RESP;
				end else begin
					re_c    = 1'b1;
					raddr_c = cursor_nx[IW-1:0];
					state_d = S_DEL_WR;
				end
			end
			S_DEL_WR: begin
				we_c     = 1'b1;
				cursor_d = cursor_nx[IW-1:0];
				state_d  = S_DEL_CHECK;
			end
			// Dump: read one element, then hand it on once the output is free.
			S_DUMP_RD: begin
				re_c    = 1'b1;
				state_d = S_DUMP_OUT;
			end
			S_DUMP_OUT: begin
				if (out_free) begin
					out_load_c   = 1'b1;
					out_has_c    = 1'b1;
					out_value_c  = rdata_q;
					out_status_c = ST_DONE;
					out_last_c   = (cursor_nx == length_q);
					if (cursor_nx == length_q) begin
						state_d = S_IDLE;
					end else begin
						cursor_d = cursor_nx[IW-1:0];
						state_d  = S_DUMP_RD;
					end
				end
			end
			S_RESP: begin
				if (out_free) begin
					out_load_c = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			length_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			length_q <= length_d;
			if (out_load_c) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working and response payload registers.
	always_ff @(posedge clk) begin
		cursor_q <= cursor_d;
		target_q <= target_d;
		value_q  <= value_d;
		status_q <= status_d;
		if (out_load_c) begin
			out_status_q <= out_status_c;
			out_len_q    <= length_q;
			out_has_q    <= out_has_c;
			out_value_q  <= out_value_c;
			out_last_q   <= out_last_c;
		end
	end

	// Element store ports.
	always_ff @(posedge clk) begin
		if (we_c) begin
			mem[waddr_c] <= wdata_c;
		end
		if (re_c) begin
			rdata_q <= mem[raddr_c];
		end
	end

	assign len_ext       = 32'(out_len_q);
	assign out_valid     = out_valid_q;
	assign status        = out_status_q;
	assign element_count = len_ext[CNT_W-1:0];
	assign has_element   = out_has_q;
	assign element_value = out_value_q;
	assign last          = out_last_q;

endmodule

[bench/list_result_checker.sv]
`timescale 1ns / 100ps

// Watches both channels of the list engine, keeps a shadow copy of the list,
// works out the responses of every accepted request and compares them, field
// by field, with what the block returns.
module list_result_checker #(
	parameter int CAPACITY = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [2:0]         command,
	input  logic signed [31:0] item_value,
	input  logic signed [7:0]  position,
	input  logic               out_valid,
	input  logic               out_ready,
	input  ple_pkg::status_t   status,
	input  logic [4:0]         element_count,
	input  logic               has_element,
	input  logic signed [31:0] element_value,
	input  logic               last,
	output int                 mismatch_count,
	output int                 outstanding
);
	import ple_pkg::*;

	typedef struct packed {
		status_t            status;
		logic [4:0]         count;
		logic               has_elem;
		logic signed [31:0] value;
		logic               is_last;
	} list_response_t;

	// Shadow of the stored list; index 0 is the head.
	logic signed [31:0] shadow_list [CAPACITY];
	int                 shadow_len;
	list_response_t     awaited_responses [$];
	int                 errors;

	// Queues one expected response, carrying the list length after the edit.
	function automatic void push_response(input status_t st, input logic has,
			input logic signed [31:0] v, input logic fin);
		list_response_t r;
		r.status   = st;
		r.count    = 5'(shadow_len);
		r.has_elem = has;
		r.value    = v;
		r.is_last  = fin;
		awaited_responses.push_back(r);
	endfunction

	// Inserts at an index, clamped to the tail; a full list drops the value.
	function automatic status_t list_insert(input int idx, input logic signed [31:0] v);
		int i;
		if (shadow_len >= CAPACITY)
			return ST_FULL;
		if (idx > shadow_len)
			idx = shadow_len;
		for (i = shadow_len; i > idx; i--)
			shadow_list[i] = shadow_list[i - 1];
		shadow_list[idx] = v;
		shadow_len++;
		return ST_DONE;
	endfunction

	// Removes the element at an index, if there is one.
	function automatic status_t list_remove(input int idx);
		int i;
		if (idx >= shadow_len)
			return ST_NONE;
		for (i = idx; i + 1 < shadow_len; i++)
			shadow_list[i] = shadow_list[i + 1];
		shadow_len--;
		return ST_DONE;
	endfunction

	// Applies one request to the shadow list and queues its responses.
	task automatic apply_list_request(input logic [2:0] cmd,
			input logic signed [31:0] val, input logic signed [7:0] pos);
		status_t st;
		int      i;
		st = ST_DONE;
		case (cmd)
			CMD_INS_HEAD: st = list_insert(0, val);
			CMD_INS_TAIL: st = list_insert(shadow_len, val);
			CMD_INS_AT: begin
				if (pos <= 0)
					st = list_insert(0, val);
				else
					st = list_insert(int'(pos), val);
			end
			CMD_DEL_HEAD: st = list_remove(0);
			CMD_DEL_TAIL: begin
				if (shadow_len == 0)
					st = ST_NONE;
				else
					st = list_remove(shadow_len - 1);
			end
			CMD_DEL_AT: begin
				if (pos < 0)
					st = ST_NONE;
				else
					st = list_remove(int'(pos));
			end
			CMD_DUMP: begin
				// An empty list still answers once, with no element.
				if (shadow_len == 0)
					push_response(ST_DONE, 1'b0, '0, 1'b1);
				for (i = 0; i < shadow_len; i++)
					push_response(ST_DONE, 1'b1, shadow_list[i], i == shadow_len - 1);
				return;
			end
			default: st = ST_DONE;
		endcase
		push_response(st, 1'b0, '0, 1'b1);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch, expected 0x%0h, got 0x%0h",
				$time, name, want, got);
		end
	endtask

	// Prediction on the request side, comparison on the response side.
	always @(posedge clk or negedge arst_n) begin
		list_response_t want;
		if (!arst_n) begin
			shadow_len = 0;
			awaited_responses.delete();
			errors = 0;
			mismatch_count <= 0;
			outstanding <= 0;
		end else begin
			if (in_valid && in_ready)
				apply_list_request(command, item_value, position);
			if (out_valid && out_ready) begin
				if (awaited_responses.size() == 0) begin
					errors++;
					$display({"%0t: unexpected response, expected none, ",
						"got status %0d count %0d value 0x%0h last %0b"},
						$time, status, element_count, element_value, last);
				end else begin
					want = awaited_responses.pop_front();
					check_field("status", 32'(want.status), 32'(status));
					check_field("element_count", 32'(want.count), 32'(element_count));
					check_field("has_element", 32'(want.has_elem), 32'(has_element));
					check_field("element_value", want.value, element_value);
					check_field("last", 32'(want.is_last), 32'(last));
				end
			end
			mismatch_count <= errors;
			outstanding <= awaited_responses.size();
		end
	end

endmodule

[bench/tb_positional_list_engine.sv]
`timescale 1ns / 100ps

module tb_positional_list_engine;
	import ple_pkg::*;

	localparam int          LIST_CAPACITY  = 16;
	localparam int          HALF_PERIOD    = 5;
	localparam int          RESET_CYCLES   = 9;
	localparam int          RANDOM_ITEMS   = 310;
	localparam int          DRAIN_CYCLES   = 60;
	localparam int          WATCHDOG_LIMIT = 2000;
	localparam logic [2:0]  CMD_UNKNOWN    = 3'd7;

	logic               clk           = 1'b0;
	logic               arst_n        = 1'b0;
	logic               in_valid      = 1'b0;
	logic               in_ready;
	logic [2:0]         command       = CMD_DUMP;
	logic signed [31:0] item_value    = '0;
	logic signed [7:0]  position      = '0;
	logic               out_valid;
	logic               out_ready     = 1'b0;
	status_t            status;
	logic [4:0]         element_count;
	logic               has_element;
	logic signed [31:0] element_value;
	logic               last;

	int mismatch_count;
	int outstanding;
	int list_fill = 0;
	int quiet_cycles = 0;
	int rx_mode = 0;
	int rx_window = 0;
	int stall_left = 0;

	always #HALF_PERIOD clk = ~clk;

	positional_list_engine #(
		.CAPACITY(LIST_CAPACITY)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.item_value(item_value),
		.position(position),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.element_count(element_count),
		.has_element(has_element),
		.element_value(element_value),
		.last(last)
	);

	list_result_checker #(
		.CAPACITY(LIST_CAPACITY)
	) i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.item_value(item_value),
		.position(position),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.element_count(element_count),
		.has_element(has_element),
		.element_value(element_value),
		.last(last),
		.mismatch_count(mismatch_count),
		.outstanding(outstanding)
	);

	// Presents one request and holds it until the block accepts it. The fill
	// count only steers the stimulus towards full and empty lists.
	task automatic send_request(input logic [2:0] cmd, input logic signed [31:0] val,
			input logic signed [7:0] pos);
		in_valid <= 1'b1;
		command <= cmd;
		item_value <= val;
		position <= pos;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		case (cmd)
			CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_AT: begin
				if (list_fill < LIST_CAPACITY)
					list_fill++;
			end
			CMD_DEL_HEAD, CMD_DEL_TAIL: begin
				if (list_fill > 0)
					list_fill--;
			end
			CMD_DEL_AT: begin
				if (pos >= 0 && pos < list_fill)
					list_fill--;
			end
			default: ;
		endcase
	endtask

	// Response side: the stall pattern is chosen afresh whenever rx_window wraps.
	always @(posedge clk) begin
		if (rx_window == 0)
			rx_mode <= $urandom_range(0, 3);
		rx_window <= (rx_window + 1) % 64;
		case (rx_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 3) != 0);
			2: out_ready <= ($urandom_range(0, 3) == 0);
			default: begin
				// Long stalls now and then, otherwise always ready.
				if (stall_left != 0) begin
					out_ready <= 1'b0;
					stall_left <= stall_left - 1;
				end else if ($urandom_range(0, 7) == 0) begin
					out_ready <= 1'b0;
					stall_left <= $urandom_range(4, 16);
				end else begin
					out_ready <= 1'b1;
				end
			end
		endcase
	end

	// Ends the run if neither channel moves for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Stimulus and verdict.
	initial begin
		int                 sent;
		int                 burst;
		int                 gap;
		int                 k;
		int                 pick;
		logic [2:0]         cmd;
		logic signed [31:0] val;
		logic signed [7:0]  pos;
		bit                 growing;

		growing = 1'b1;
		sent = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty list: dump, and every kind of delete finds nothing.
		send_request(CMD_DUMP, 32'sd0, 8'sd0);
		send_request(CMD_DEL_HEAD, 32'sd0, 8'sd0);
		send_request(CMD_DEL_TAIL, 32'sd0, 8'sd0);
		send_request(CMD_DEL_AT, 32'sd0, 8'sd0);

		// Inserts at both ends, at low, zero, middle and high positions.
		send_request(CMD_INS_AT, 32'h8000_0000, 8'sh80);
		send_request(CMD_INS_TAIL, 32'h7fff_ffff, 8'sh7f);
		send_request(CMD_INS_HEAD, 32'sd0, 8'sd0);
		send_request(CMD_INS_AT, -32'sd1, 8'sh7f);
		send_request(CMD_INS_AT, 32'sd1, 8'sd0);
		send_request(CMD_INS_AT, 32'h5555_aaaa, 8'sd2);
		send_request(CMD_INS_AT, 32'haaaa_5555, 8'(list_fill));
		send_request(CMD_UNKNOWN, 32'h1234_5678, 8'sh55);
		send_request(CMD_DUMP, 32'sd0, 8'sd0);

		// Deletes at bad positions, then at the boundaries and the middle.
		in_valid <= 1'b0;
		repeat (3) @(posedge clk);
		send_request(CMD_DEL_AT, 32'sd0, -8'sd1);
		send_request(CMD_DEL_AT, 32'sd0, 8'sh7f);
		send_request(CMD_DEL_AT, 32'sd0, 8'(list_fill));
		send_request(CMD_DEL_AT, 32'sd0, 8'(list_fill - 1));
		send_request(CMD_DEL_AT, 32'sd0, 8'sd0);
		send_request(CMD_DEL_AT, 32'sd0, 8'sd2);
		send_request(CMD_DEL_TAIL, 32'sd0, 8'sd0);
		send_request(CMD_DEL_HEAD, 32'sd0, 8'sd0);
		send_request(CMD_DUMP, 32'sd0, 8'sd0);
		send_request(CMD_UNKNOWN, -32'sd1, -8'sd1);

		// Random requests in bursts. The list swings between growing and
		// shrinking so that full and empty lists come up again and again.
		while (sent < RANDOM_ITEMS) begin
			burst = $urandom_range(1, 16);
			for (k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
				if (list_fill == LIST_CAPACITY && $urandom_range(0, 2) == 0)
					growing = 1'b0;
				else if (list_fill == 0 && $urandom_range(0, 2) == 0)
					growing = 1'b1;
				else if ($urandom_range(0, 49) == 0)
					growing = ~growing;

				pick = $urandom_range(0, 99);
				if (pick < 3) begin
					cmd = CMD_UNKNOWN;
				end else if (pick < 10) begin
					cmd = CMD_DUMP;
				end else if (pick < (growing ? 75 : 30)) begin
					case ($urandom_range(0, 2))
						0: cmd = CMD_INS_HEAD;
						1: cmd = CMD_INS_TAIL;
						default: cmd = CMD_INS_AT;
					endcase
				end else begin
					case ($urandom_range(0, 2))
						0: cmd = CMD_DEL_HEAD;
						1: cmd = CMD_DEL_TAIL;
						default: cmd = CMD_DEL_AT;
					endcase
				end

				case ($urandom_range(0, 11))
					0: val = 32'h8000_0000;
					1: val = 32'h7fff_ffff;
					2: val = -32'sd1;
					3: val = 32'sd0;
					default: val = $urandom;
				endcase

				case ($urandom_range(0, 7))
					0, 1: pos = 8'($urandom_range(0, 255));
					2: pos = 8'(list_fill);
					3: pos = 8'(list_fill - 1);
					default: pos = 8'($urandom_range(0, list_fill));
				endcase

				send_request(cmd, val, pos);
				sent++;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid <= 1'b0;

		// Let every awaited response arrive, then watch for strays. Waiting on the
		// clock first lets the checker count the final request.
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && outstanding == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

[files.f]
sv/ple_pkg.sv
sv/positional_list_engine.sv
bench/list_result_checker.sv
bench/tb_positional_list_engine.sv
